### hw/rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the half-pel block SAD core: pixel and sum
// widths, interpolation mode codes, register indexes and the row word.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_PIX    = 16;
    localparam int HALF_PIX   = ROW_PIX / 2;
    localparam int WORD_W     = HALF_PIX * PIX_W;
    localparam int ROW_SAD_W  = 12;
    localparam int SAD_W      = 16;
    localparam int CFG_DATA_W = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SAD_W-1:0] ACC_LIMIT = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_BLOCK = 1'b1;

    typedef enum logic [1:0] {
        MODE_FULL = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_VERT = 2'd2,
        MODE_DIAG = 2'd3
    } t_interp_mode;

    typedef struct packed {
        logic [WORD_W-1:0] cur_low;
        logic [WORD_W-1:0] cur_high;
        logic [WORD_W-1:0] ref_top_low;
        logic [WORD_W-1:0] ref_top_high;
        logic [PIX_W-1:0]  ref_top_extra;
        logic [WORD_W-1:0] ref_bot_low;
        logic [WORD_W-1:0] ref_bot_high;
        logic [PIX_W-1:0]  ref_bot_extra;
        logic              last_row;
    } t_row_item;

endpackage

### hw/rtl/hps_row_sad.sv
// ----------------------------------------------------------------------------
// hps_row_sad
// Row SAD datapath: forms the reference prediction for each of the 16
// current pixels and sums the absolute differences through an adder tree.
// ----------------------------------------------------------------------------
module hps_row_sad (
    input  hps_pkg::t_row_item              i_item,
    input  hps_pkg::t_interp_mode           i_mode,
    input  logic                            i_narrow,
    output logic [hps_pkg::ROW_SAD_W-1:0]   o_row_sad
);
    import hps_pkg::*;

    logic [(ROW_PIX+1)*PIX_W-1:0] w_top_row;
    logic [(ROW_PIX+1)*PIX_W-1:0] w_bot_row;
    logic [ROW_PIX*PIX_W-1:0]     w_cur_row;
    logic [PIX_W-1:0]             w_diff [ROW_PIX];
    logic [PIX_W:0]               w_sum1 [ROW_PIX/2];
    logic [PIX_W+1:0]             w_sum2 [ROW_PIX/4];
    logic [PIX_W+2:0]             w_sum3 [ROW_PIX/8];

    assign w_top_row = {i_item.ref_top_extra, i_item.ref_top_high, i_item.ref_top_low};
    assign w_bot_row = {i_item.ref_bot_extra, i_item.ref_bot_high, i_item.ref_bot_low};
    assign w_cur_row = {i_item.cur_high, i_item.cur_low};

    always_comb begin
        logic [PIX_W-1:0] a, b, c, d, cur, pred;
        logic [PIX_W:0]   pair;
        logic [PIX_W+1:0] quad;
        for (int k = 0; k < ROW_PIX; k++) begin
            a    = w_top_row[k*PIX_W +: PIX_W];
            b    = w_top_row[(k+1)*PIX_W +: PIX_W];
            c    = w_bot_row[k*PIX_W +: PIX_W];
            d    = w_bot_row[(k+1)*PIX_W +: PIX_W];
            cur  = w_cur_row[k*PIX_W +: PIX_W];
            pair = '0;
            quad = '0;
            unique case (i_mode)
                MODE_FULL: begin
                    pred = a;
                end
                MODE_HORZ: begin
                    pair = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
                    pred = pair[PIX_W:1];
                end
                MODE_VERT: begin
                    pair = {1'b0, a} + {1'b0, c} + (PIX_W+1)'(1);
                    pred = pair[PIX_W:1];
                end
                MODE_DIAG: begin
                    quad = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d}
                         + (PIX_W+2)'(2);
                    pred = quad[PIX_W+1:2];
                end
                default: begin
                    pred = a;
                end
            endcase
            w_diff[k] = (cur > pred) ? (cur - pred) : (pred - cur);
            // Narrow full-pel blocks compare the left half only
            if (i_mode == MODE_FULL && i_narrow && k >= HALF_PIX) begin
                w_diff[k] = '0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ROW_PIX/2; k++) begin
            w_sum1[k] = {1'b0, w_diff[2*k]} + {1'b0, w_diff[2*k+1]};
        end
        for (int k = 0; k < ROW_PIX/4; k++) begin
            w_sum2[k] = {1'b0, w_sum1[2*k]} + {1'b0, w_sum1[2*k+1]};
        end
        for (int k = 0; k < ROW_PIX/8; k++) begin
            w_sum3[k] = {1'b0, w_sum2[2*k]} + {1'b0, w_sum2[2*k+1]};
        end
        o_row_sad = {1'b0, w_sum3[0]} + {1'b0, w_sum3[1]};
    end

endmodule

### hw/rtl/half_pel_block_sad_core.sv
// ----------------------------------------------------------------------------
// half_pel_block_sad_core
// Motion-estimation SAD engine with full-pel and half-pel reference
// prediction, one block row per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): one word is one block row, the
//   16 current pixels and reference rows i and i+1 (17 pixels each). A word
//   is taken on an edge with i_in_valid high and o_in_stall low.
//   Output channel (o_out_valid / i_out_stall): one word carrying the block
//   SAD, produced only for a row with i_last_row set.
//   Throughput: one row per cycle while o_in_stall is low. The row register and the result register
//   are the only stages; the row SAD, the accumulate and the saturation run
//   between them, so the limit is that single adder path.
//   Result path: the edge that takes the last row loads the row register;
//   the total then goes into the result register once that register is free.
//   Stall: rows without the last mark never wait. A last row waits in the
//   row register only while an earlier total still sits unclaimed in the
//   result register, and o_in_stall rises in that case alone.
//   Configuration (i_cfg_we): index 0 sets interp_mode, index 1 sets
//   narrow_block; write only while the core is idle.
//   Reset: clears both valid flags, the running sum and the configuration
//   registers (full-pel mode, wide block).
// ----------------------------------------------------------------------------
module half_pel_block_sad_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [hps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // row input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hps_pkg::WORD_W-1:0]        i_cur_low,
    input  logic [hps_pkg::WORD_W-1:0]        i_cur_high,
    input  logic [hps_pkg::WORD_W-1:0]        i_ref_top_low,
    input  logic [hps_pkg::WORD_W-1:0]        i_ref_top_high,
    input  logic [hps_pkg::PIX_W-1:0]         i_ref_top_extra,
    input  logic [hps_pkg::WORD_W-1:0]        i_ref_bot_low,
    input  logic [hps_pkg::WORD_W-1:0]        i_ref_bot_high,
    input  logic [hps_pkg::PIX_W-1:0]         i_ref_bot_extra,
    input  logic                              i_last_row,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hps_pkg::SAD_W-1:0]         o_sad_total
);
    import hps_pkg::*;

    // configuration registers
    t_interp_mode r_interp_mode;
    logic         r_narrow_block;

    // row register
    logic         r_row_valid;
    t_row_item    r_row;
    t_row_item    w_in_item;

    // running sum and result register
    logic [SAD_W-1:0] r_sad_accum;
    logic [SAD_W-1:0] n_sad_accum;
    logic             r_out_valid;
    logic [SAD_W-1:0] r_sad_total;

    logic [ROW_SAD_W-1:0] w_row_sad;
    logic [SAD_W:0]       w_total_wide;
    logic [SAD_W-1:0]     w_total;
    logic                 w_out_free;
    logic                 w_row_adv;
    logic                 w_in_take;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode  <= MODE_FULL;
            r_narrow_block <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERP_MODE:  r_interp_mode  <= t_interp_mode'(i_cfg_data[1:0]);
                CFG_NARROW_BLOCK: r_narrow_block <= i_cfg_data[0];
                default:          r_narrow_block <= r_narrow_block;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    // The result register is free when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // A held row moves on unless it must publish a total into a busy slot.
    assign w_row_adv  = r_row_valid && (!r_row.last_row || w_out_free);
    assign o_in_stall = r_row_valid && !w_row_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_in_item = '{
        cur_low:       i_cur_low,
        cur_high:      i_cur_high,
        ref_top_low:   i_ref_top_low,
        ref_top_high:  i_ref_top_high,
        ref_top_extra: i_ref_top_extra,
        ref_bot_low:   i_ref_bot_low,
        ref_bot_high:  i_ref_bot_high,
        ref_bot_extra: i_ref_bot_extra,
        last_row:      i_last_row
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= 1'b0;
        end else if (w_in_take) begin
            r_row_valid <= 1'b1;
        end else if (w_row_adv) begin
            r_row_valid <= 1'b0;
        end
    end

    // Payload: load on take, otherwise hold
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_row <= w_in_item;
        end
    end

    // ------------------------------------------------------------------
    // Row SAD and accumulate
    // ------------------------------------------------------------------
    hps_row_sad u_row_sad (
        .i_item    (r_row),
        .i_mode    (r_interp_mode),
        .i_narrow  (r_narrow_block),
        .o_row_sad (w_row_sad)
    );

    // Saturate at the 16-bit limit rather than wrap on overlong blocks
    assign w_total_wide = {1'b0, r_sad_accum} + (SAD_W+1)'(w_row_sad);
    assign w_total      = w_total_wide[SAD_W] ? ACC_LIMIT : w_total_wide[SAD_W-1:0];

    always_comb begin
        n_sad_accum = r_sad_accum;
        if (w_row_adv) begin
            n_sad_accum = r_row.last_row ? '0 : w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sad_accum <= '0;
        end else begin
            r_sad_accum <= n_sad_accum;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_row_adv && r_row.last_row) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_row_adv && r_row.last_row) begin
            r_sad_total <= w_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sad_total = r_sad_total;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_publishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_row_adv && r_row.last_row) |=> (r_out_valid && r_sad_accum == '0))
        else $error("last row did not publish a total and clear the sum");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_row_valid && r_row.last_row && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked last row");

    a_sat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_row_adv && !r_row.last_row && r_sad_accum == ACC_LIMIT)
            |=> (r_sad_accum == ACC_LIMIT))
        else $error("saturated sum wrapped");

    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_row_adv |=> (r_sad_accum == $past(r_sad_accum)))
        else $error("running sum changed without a row");

endmodule
